// File: src/lsft_pkg.sv
// lsft_pkg: types and constants shared by the led string frame transmitter
// no dependencies; imported by the register file, the line engine and the top level
`timescale 1ns / 1ps

package lsft_pkg;

	// register indexes on the configuration port
	localparam int unsigned RegUnitTicks    = 0;
	localparam int unsigned RegIntensityCap = 1;

	// reset values of the configuration registers
	localparam logic [15:0] UnitTicksReset    = 16'd10;
	localparam logic [7:0]  IntensityCapReset = 8'd204;

	// frame geometry
	localparam int unsigned FrameBits   = 26;
	localparam int unsigned BitsLeftW   = 5;
	localparam int unsigned UnitsPerSym = 3;

	// input item kinds
	localparam logic KindTick = 1'b0;
	localparam logic KindSend = 1'b1;

	// transmitter phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_BITS  = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	// configuration seen by the line engine
	typedef struct packed {
		logic [15:0] unit_ticks;
		logic [7:0]  intensity_cap;
	} cfg_t;

	// one input item
	typedef struct packed {
		logic       kind;
		logic [5:0] address;
		logic [7:0] intensity;
		logic [3:0] red;
		logic [3:0] green;
		logic [3:0] blue;
	} item_t;

	// one result item
	typedef struct packed {
		logic line;
		logic busy_res;
		logic accepted;
		logic frame_done;
	} res_t;

endpackage

// File: src/lsft_regs.sv
// lsft_regs: apb register file holding unit_ticks and intensity_cap
// depends on lsft_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module lsft_regs import lsft_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [15:0] unit_ticks_q;
	logic [7:0]  intensity_cap_q;
	logic        wr_en;
	logic        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[2];

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q    <= UnitTicksReset;
			intensity_cap_q <= IntensityCapReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				1'(RegUnitTicks):    unit_ticks_q    <= pwdata[15:0];
				1'(RegIntensityCap): intensity_cap_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			1'(RegUnitTicks):    prdata = {16'd0, unit_ticks_q};
			1'(RegIntensityCap): prdata = {24'd0, intensity_cap_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg.unit_ticks    = unit_ticks_q;
	assign cfg.intensity_cap = intensity_cap_q;

endmodule

// File: src/lsft_engine.sv
// lsft_engine: line code state machine, one item per step
// depends on lsft_pkg for phase_t, cfg_t, item_t and res_t
`timescale 1ns / 1ps

module lsft_engine import lsft_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	phase_t                 phase_q, phase_d;
	logic [FrameBits-1:0]   shift_q, shift_d;
	logic [BitsLeftW-1:0]   bits_left_q, bits_left_d;
	logic [1:0]             unit_q, unit_d;
	logic [15:0]            tick_q, tick_d;
	logic                   accepted_d;
	logic                   done_d;
	logic [15:0]            unit_len;
	logic                   unit_end;
	logic [7:0]             inten_capped;

	// zero length counts as one tick
	assign unit_len     = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
	assign unit_end     = ({1'b0, tick_q} + 17'd1) >= {1'b0, unit_len};
	assign inten_capped = (item.intensity > cfg.intensity_cap) ? cfg.intensity_cap
	                                                           : item.intensity;

	// next state
	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bits_left_d = bits_left_q;
		unit_d      = unit_q;
		tick_d      = tick_q;
		accepted_d  = 1'b0;
		done_d      = 1'b0;
		if (step) begin
			if (item.kind == KindSend) begin
				// requests while busy are dropped
				if (phase_q == PH_IDLE) begin
					shift_d     = {item.address, inten_capped, item.blue, item.green, item.red};
					phase_d     = PH_START;
					bits_left_d = '0;
					unit_d      = '0;
					tick_d      = '0;
					accepted_d  = 1'b1;
				end
			end else if (phase_q != PH_IDLE) begin
				if (!unit_end) begin
					tick_d = tick_q + 16'd1;
				end else begin
					tick_d = '0;
					unique case (phase_q)
						PH_START: begin
							phase_d     = PH_BITS;
							bits_left_d = BitsLeftW'(FrameBits);
							unit_d      = '0;
						end
						PH_BITS: begin
							if (unit_q == 2'(UnitsPerSym - 1)) begin
								unit_d      = '0;
								shift_d     = {shift_q[FrameBits-2:0], 1'b0};
								bits_left_d = bits_left_q - BitsLeftW'(1);
								if (bits_left_q == BitsLeftW'(1)) begin
									phase_d = PH_END;
								end
							end else begin
								unit_d = unit_q + 2'd1;
							end
						end
						PH_END: begin
							if (unit_q == 2'(UnitsPerSym - 1)) begin
								unit_d  = '0;
								phase_d = PH_IDLE;
								done_d  = 1'b1;
							end else begin
								unit_d = unit_q + 2'd1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			bits_left_q <= '0;
			unit_q      <= '0;
			tick_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			bits_left_q <= bits_left_d;
			unit_q      <= unit_d;
			tick_q      <= tick_d;
		end
	end

	// result of this step, from the updated state
	always_comb begin
		unique case (phase_d)
			PH_START: res.line = 1'b1;
			PH_BITS:  res.line = shift_d[FrameBits-1] ? (unit_d >= 2'd2) : (unit_d >= 2'd1);
			default:  res.line = 1'b0;
		endcase
		res.busy_res   = (phase_d != PH_IDLE);
		res.accepted   = accepted_d;
		res.frame_done = done_d;
	end

endmodule

// File: src/led_string_frame_transmitter.sv
// led_string_frame_transmitter: top level with input register, line engine and result register
// depends on lsft_pkg, lsft_regs and lsft_engine
// path: a transaction accepted on s_axis is captured in the input register s1, the engine
// steps once on it, and the result register s2 holds the result for m_axis (stages s1 and s2)
// throughput: one item per cycle unless m_axis stalls; the engine updates between s1 and s2
// every item gives exactly one result; a stalled master side holds the result and s1
// reset: arst_n clears the pipeline valids, the engine state (idle, line low) and loads
// unit_ticks = 10 and intensity_cap = 204
`timescale 1ns / 1ps

module led_string_frame_transmitter import lsft_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // address[5:0], intensity[13:6], red[17:14],
	                                   // green[21:18], blue[25:22], zero[31:26]
	input  logic        s_axis_tuser,  // kind[0]
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // line[0], busy_res[1], accepted[2], zero[7:3]
	output logic        m_axis_tlast   // frame_done
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_comb;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv_s2;
	logic  adv_s1;

	lsft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline flow control
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind      <= s_axis_tuser;
			item_s1.address   <= s_axis_tdata[5:0];
			item_s1.intensity <= s_axis_tdata[13:6];
			item_s1.red       <= s_axis_tdata[17:14];
			item_s1.green     <= s_axis_tdata[21:18];
			item_s1.blue      <= s_axis_tdata[25:22];
		end
	end

	lsft_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.accepted, res_s2.busy_res, res_s2.line};
	assign m_axis_tlast  = res_s2.frame_done;

endmodule

// File: src/lsft_checker.sv
// lsft_checker: port-level assertions for led_string_frame_transmitter
// depends on the top level port list; bound to it at the end of this file
`timescale 1ns / 1ps

module lsft_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	// a taken request starts the frame: busy with the start mark high
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1] && m_axis_tdata[0])
		else $error("accepted request without busy start mark");

	// end of the quiet gap leaves the line idle and low
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1] && !m_axis_tdata[0])
		else $error("frame_done while busy or line high");

	// a frame never ends on the same item that starts one
	a_done_not_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
		else $error("frame_done together with accepted");

	// stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

endmodule

bind led_string_frame_transmitter lsft_checker u_lsft_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
